// File: hdl/sfbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept face bounds package
// Shared constants, register indexes, controller types and the saturating add
// used by the swept face bounds and centroid block.
// ----------------------------------------------------------------------------
package sfbc_pkg;

    // Default upper limit on the faces counted in one mesh.
    localparam int DEF_MAX_FACES = 65536;

    // Fixed field widths.
    localparam int COORD_W   = 32;
    localparam int IDX_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_AXES  = 3;

    // Six quotients per mesh: start centroid x, y, z then end centroid x, y, z.
    localparam int NUM_QUOT = 6;
    localparam int SEL_W    = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTROID_EN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_DX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_DY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_DZ    = 3'd4;

    // Sweep modes; the unused code behaves as static.
    localparam logic [1:0] MODE_STATIC = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_ROTATE = 2'd2;

    // Result kinds.
    localparam logic KIND_BOX  = 1'b0;
    localparam logic KIND_PAIR = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PAIR
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             vtx_accept;
        logic             div_start;
        logic [SEL_W-1:0] div_sel;
        logic             quot_store;
        logic             pair_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pair_due;
        logic div_done;
        logic out_free;
    } t_status;

    // Signed 32-bit add that clamps to the representable range.
    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                 : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            sat_add = s[COORD_W-1:0];
        end
    endfunction

endpackage

// File: hdl/sfbc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centroid divider
// Restoring signed divider, one quotient bit per cycle, truncating toward
// zero. Returns the low 32 bits of the quotient.
// ----------------------------------------------------------------------------
module sfbc_div #(
    parameter int DVD_W = 51,
    parameter int DVS_W = 19
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [DVD_W-1:0]              i_dividend,
    input  logic        [DVS_W-1:0]              i_divisor,
    output logic                                 o_done,
    output logic signed [sfbc_pkg::COORD_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_shift;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic             r_neg;

    logic [DVS_W:0]   trial;
    logic             q_bit;
    logic [DVS_W:0]   rem_next;

    // One trial subtraction per cycle.
    always_comb begin
        trial    = {r_rem, r_shift[DVD_W-1]};
        q_bit    = (trial >= {1'b0, r_dvs});
        rem_next = q_bit ? (trial - {1'b0, r_dvs}) : trial;
    end

    // Control: busy flag, step count and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Operands: the dividend magnitude shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend[DVD_W-1] ? (DVD_W'(0) - i_dividend) : i_dividend;
            r_neg   <= i_dividend[DVD_W-1];
            r_dvs   <= i_divisor;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[DVD_W-2:0], q_bit};
            r_rem   <= rem_next[DVS_W-1:0];
        end
    end

    // Sign is applied to the magnitude quotient.
    assign o_quot = r_neg ? (sfbc_pkg::COORD_W'(0) - r_shift[sfbc_pkg::COORD_W-1:0])
                          : r_shift[sfbc_pkg::COORD_W-1:0];
    assign o_done = r_done;

endmodule

// File: hdl/sfbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept face bounds controller
// Accepts vertex requests, runs the six centroid divisions at a mesh end with
// centroids enabled and hands the centroid pair to the output register.
// ----------------------------------------------------------------------------
module sfbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sfbc_pkg::t_status i_status,
    output sfbc_pkg::t_cmd    o_cmd
);

    sfbc_pkg::t_state                r_state;
    sfbc_pkg::t_state                n_state;
    logic [sfbc_pkg::SEL_W-1:0]      r_sel;
    logic [sfbc_pkg::SEL_W-1:0]      n_sel;

    // State and quotient select registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfbc_pkg::ST_IDLE;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        n_sel         = r_sel;
        o_cmd         = '0;
        o_cmd.div_sel = r_sel;
        o_in_ready    = 1'b0;
        unique case (r_state)
            sfbc_pkg::ST_IDLE: begin
                o_in_ready       = i_status.out_free;
                o_cmd.vtx_accept = i_in_valid && i_status.out_free;
                if (o_cmd.vtx_accept && i_status.pair_due) begin
                    n_state = sfbc_pkg::ST_DIV_GO;
                    n_sel   = '0;
                end
            end
            sfbc_pkg::ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = sfbc_pkg::ST_DIV_WAIT;
            end
            sfbc_pkg::ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.quot_store = 1'b1;
                    if (r_sel == sfbc_pkg::SEL_W'(sfbc_pkg::NUM_QUOT - 1)) begin
                        n_state = sfbc_pkg::ST_PAIR;
                    end else begin
                        n_sel   = r_sel + sfbc_pkg::SEL_W'(1);
                        n_state = sfbc_pkg::ST_DIV_GO;
                    end
                end
            end
            sfbc_pkg::ST_PAIR: begin
                if (i_status.out_free) begin
                    o_cmd.pair_load = 1'b1;
                    n_state         = sfbc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sfbc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/sfbc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept face bounds datapath
// Configuration registers, running face box, centroid sums, face counter,
// the shared divider and the output register.
// ----------------------------------------------------------------------------
module sfbc_dp #(
    parameter int MAX_FACES = sfbc_pkg::DEF_MAX_FACES
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sfbc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sfbc_pkg::COORD_W-1:0]          i_cfg_data,
    input  logic signed [sfbc_pkg::COORD_W-1:0]   i_vertex_x,
    input  logic signed [sfbc_pkg::COORD_W-1:0]   i_vertex_y,
    input  logic signed [sfbc_pkg::COORD_W-1:0]   i_vertex_z,
    input  logic signed [sfbc_pkg::COORD_W-1:0]   i_disp_x,
    input  logic signed [sfbc_pkg::COORD_W-1:0]   i_disp_y,
    input  logic signed [sfbc_pkg::COORD_W-1:0]   i_disp_z,
    input  logic                                  i_end_of_mesh,
    input  sfbc_pkg::t_cmd                        i_cmd,
    output sfbc_pkg::t_status                     o_status,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_result_kind,
    output logic [sfbc_pkg::IDX_W-1:0]            o_face_index,
    output logic signed [sfbc_pkg::COORD_W-1:0]   o_a_x,
    output logic signed [sfbc_pkg::COORD_W-1:0]   o_a_y,
    output logic signed [sfbc_pkg::COORD_W-1:0]   o_a_z,
    output logic signed [sfbc_pkg::COORD_W-1:0]   o_b_x,
    output logic signed [sfbc_pkg::COORD_W-1:0]   o_b_y,
    output logic signed [sfbc_pkg::COORD_W-1:0]   o_b_z,
    output logic                                  o_last_of_run
);

    localparam int CW    = sfbc_pkg::COORD_W;
    localparam int NA    = sfbc_pkg::NUM_AXES;
    localparam int CNT_W = $clog2(MAX_FACES + 1);
    localparam int SUM_W = CW + $clog2(3 * MAX_FACES) + 1;
    localparam int DVS_W = CNT_W + 2;

    // Configuration registers.
    logic [1:0]              r_mode;
    logic                    r_cen;
    logic signed [CW-1:0]    r_sweep [NA];

    // Mesh state.
    logic [1:0]              r_corner;
    logic [CNT_W-1:0]        r_count;
    logic signed [CW-1:0]    r_low   [NA];
    logic signed [CW-1:0]    r_high  [NA];
    logic signed [SUM_W-1:0] r_ssum  [NA];
    logic signed [SUM_W-1:0] r_esum  [NA];
    logic signed [CW-1:0]    r_quot  [sfbc_pkg::NUM_QUOT];

    // Output register.
    logic                    r_out_valid;
    logic                    r_kind;
    logic [sfbc_pkg::IDX_W-1:0] r_index;
    logic signed [CW-1:0]    r_a [NA];
    logic signed [CW-1:0]    r_b [NA];
    logic                    r_last;

    logic signed [CW-1:0]    v       [NA];
    logic signed [CW-1:0]    dsp     [NA];
    logic signed [CW-1:0]    n_low   [NA];
    logic signed [CW-1:0]    n_high  [NA];
    logic signed [CW-1:0]    box_lo  [NA];
    logic signed [CW-1:0]    box_hi  [NA];
    logic signed [CW-1:0]    pair_b  [NA];
    logic                    rot;
    logic                    counting;
    logic                    face_end;
    logic                    out_free;
    logic signed [SUM_W-1:0] dividend;
    logic [DVS_W-1:0]        divisor;
    logic                    div_done;
    logic signed [CW-1:0]    div_q;

    assign o_cfg_ready = 1'b1;

    assign v[0]   = i_vertex_x;
    assign v[1]   = i_vertex_y;
    assign v[2]   = i_vertex_z;
    assign dsp[0] = sfbc_pkg::sat_add(i_vertex_x, i_disp_x);
    assign dsp[1] = sfbc_pkg::sat_add(i_vertex_y, i_disp_y);
    assign dsp[2] = sfbc_pkg::sat_add(i_vertex_z, i_disp_z);

    assign rot      = (r_mode == sfbc_pkg::MODE_ROTATE);
    assign counting = (r_count < CNT_W'(MAX_FACES));
    assign face_end = (r_corner == 2'd2);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_status.pair_due = face_end && i_end_of_mesh && r_cen;
    assign o_status.div_done = div_done;
    assign o_status.out_free = out_free;

    // Box growth for the incoming vertex (and its displaced copy in rotate mode), then the linear sweep at face end.
    always_comb begin
        for (int k = 0; k < NA; k++) begin
            if (r_corner == 2'd0) begin
                n_low[k]  = v[k];
                n_high[k] = v[k];
            end else begin
                n_low[k]  = (v[k] < r_low[k])  ? v[k] : r_low[k];
                n_high[k] = (v[k] > r_high[k]) ? v[k] : r_high[k];
            end
            if (rot) begin
                if (dsp[k] < n_low[k])  n_low[k]  = dsp[k];
                if (dsp[k] > n_high[k]) n_high[k] = dsp[k];
            end
            box_lo[k] = n_low[k];
            box_hi[k] = n_high[k];
            if (r_mode == sfbc_pkg::MODE_LINEAR) begin
                if (r_sweep[k][CW-1]) box_lo[k] = sfbc_pkg::sat_add(n_low[k], r_sweep[k]);
                else                  box_hi[k] = sfbc_pkg::sat_add(n_high[k], r_sweep[k]);
            end
        end
    end

    // End centroid by mode.
    always_comb begin
        for (int k = 0; k < NA; k++) begin
            if (r_mode == sfbc_pkg::MODE_ROTATE) begin
                pair_b[k] = r_quot[NA + k];
            end else if (r_mode == sfbc_pkg::MODE_LINEAR) begin
                pair_b[k] = sfbc_pkg::sat_add(r_quot[k], r_sweep[k]);
            end else begin
                pair_b[k] = '0;
            end
        end
    end

    // Divider operand selection: three times the face count as divisor.
    assign divisor = {1'b0, r_count, 1'b0} + {2'b00, r_count};

    always_comb begin
        case (i_cmd.div_sel)
            3'd0:    dividend = r_ssum[0];
            3'd1:    dividend = r_ssum[1];
            3'd2:    dividend = r_ssum[2];
            3'd3:    dividend = r_esum[0];
            3'd4:    dividend = r_esum[1];
            default: dividend = r_esum[2];
        endcase
    end

    sfbc_div #(
        .DVD_W (SUM_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sfbc_pkg::MODE_STATIC;
            r_cen  <= 1'b1;
            for (int k = 0; k < NA; k++) r_sweep[k] <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sfbc_pkg::CFG_SWEEP_MODE:  r_mode     <= i_cfg_data[1:0];
                sfbc_pkg::CFG_CENTROID_EN: r_cen      <= i_cfg_data[0];
                sfbc_pkg::CFG_SWEEP_DX:    r_sweep[0] <= i_cfg_data;
                sfbc_pkg::CFG_SWEEP_DY:    r_sweep[1] <= i_cfg_data;
                sfbc_pkg::CFG_SWEEP_DZ:    r_sweep[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Corner position, face counter and centroid sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
            r_count  <= '0;
            for (int k = 0; k < NA; k++) begin
                r_ssum[k] <= '0;
                r_esum[k] <= '0;
            end
        end else if (i_cmd.vtx_accept) begin
            r_corner <= face_end ? 2'd0 : r_corner + 2'd1;
            if (counting) begin
                for (int k = 0; k < NA; k++) begin
                    r_ssum[k] <= r_ssum[k] + SUM_W'(v[k]);
                    if (rot) r_esum[k] <= r_esum[k] + SUM_W'(dsp[k]);
                end
            end
            if (face_end) begin
                if (counting) r_count <= r_count + CNT_W'(1);
                // Mesh end without centroids clears at once.
                if (i_end_of_mesh && !r_cen) begin
                    r_count <= '0;
                    for (int k = 0; k < NA; k++) begin
                        r_ssum[k] <= '0;
                        r_esum[k] <= '0;
                    end
                end
            end
        end else if (i_cmd.pair_load) begin
            r_count <= '0;
            for (int k = 0; k < NA; k++) begin
                r_ssum[k] <= '0;
                r_esum[k] <= '0;
            end
        end
    end

    // Running box and quotient store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.vtx_accept) begin
            for (int k = 0; k < NA; k++) begin
                r_low[k]  <= n_low[k];
                r_high[k] <= n_high[k];
            end
        end
        if (i_cmd.quot_store) begin
            r_quot[i_cmd.div_sel] <= div_q;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pair_load || (i_cmd.vtx_accept && face_end)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload: face box or centroid pair.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_load) begin
            r_kind  <= sfbc_pkg::KIND_PAIR;
            r_index <= sfbc_pkg::IDX_W'(r_count - CNT_W'(1));
            r_last  <= 1'b1;
            for (int k = 0; k < NA; k++) begin
                r_a[k] <= r_quot[k];
                r_b[k] <= pair_b[k];
            end
        end else if (i_cmd.vtx_accept && face_end) begin
            r_kind  <= sfbc_pkg::KIND_BOX;
            r_index <= sfbc_pkg::IDX_W'(r_count);
            r_last  <= !(i_end_of_mesh && r_cen);
            for (int k = 0; k < NA; k++) begin
                r_a[k] <= box_lo[k];
                r_b[k] <= box_hi[k];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_face_index  = r_index;
    assign o_a_x         = r_a[0];
    assign o_a_y         = r_a[1];
    assign o_a_z         = r_a[2];
    assign o_b_x         = r_b[0];
    assign o_b_y         = r_b[1];
    assign o_b_z         = r_b[2];
    assign o_last_of_run = r_last;

endmodule

// File: hdl/swept_face_bounds_and_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept face bounds and centroid
// Streams triangle vertices, emits a swept axis-aligned box per face and a
// start/end centroid pair at the end of each mesh with centroids enabled.
// ----------------------------------------------------------------------------
// Usage:
// Vertex requests arrive on the input channel (valid/ready), three per face.
// Configuration is written on its own channel, always ready; the user must
// write it only while idle, and the block does not enforce this. Results
// leave through a single output register on the output channel. A vertex is
// taken every cycle while the controller is idle and the output register is
// empty or being read, so the sustained rate is one vertex per cycle. The
// face box is registered and appears in the cycle after the third vertex is
// accepted. On a mesh end with centroids enabled, six signed divisions run
// one after the other on one restoring divider of SUM_W bits, one quotient
// bit per cycle. No vertex is accepted during the divisions.
// If the receiver stalls, the held result stays and input ready drops until
// the register is free. Reset clears the face counter, sums and control
// registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module swept_face_bounds_and_centroid #(
    parameter int MAX_FACES = sfbc_pkg::DEF_MAX_FACES
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sfbc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sfbc_pkg::COORD_W-1:0]          i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [sfbc_pkg::COORD_W-1:0]   i_vertex_x,
    input  logic signed [sfbc_pkg::COORD_W-1:0]   i_vertex_y,
    input  logic signed [sfbc_pkg::COORD_W-1:0]   i_vertex_z,
    input  logic signed [sfbc_pkg::COORD_W-1:0]   i_disp_x,
    input  logic signed [sfbc_pkg::COORD_W-1:0]   i_disp_y,
    input  logic signed [sfbc_pkg::COORD_W-1:0]   i_disp_z,
    input  logic                                  i_end_of_mesh,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_result_kind,
    output logic [sfbc_pkg::IDX_W-1:0]            o_face_index,
    output logic signed [sfbc_pkg::COORD_W-1:0]   o_a_x,
    output logic signed [sfbc_pkg::COORD_W-1:0]   o_a_y,
    output logic signed [sfbc_pkg::COORD_W-1:0]   o_a_z,
    output logic signed [sfbc_pkg::COORD_W-1:0]   o_b_x,
    output logic signed [sfbc_pkg::COORD_W-1:0]   o_b_y,
    output logic signed [sfbc_pkg::COORD_W-1:0]   o_b_z,
    output logic                                  o_last_of_run
);

    sfbc_pkg::t_cmd    cmd;
    sfbc_pkg::t_status status;

    // Controller.
    sfbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath.
    sfbc_dp #(
        .MAX_FACES (MAX_FACES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_vertex_z    (i_vertex_z),
        .i_disp_x      (i_disp_x),
        .i_disp_y      (i_disp_y),
        .i_disp_z      (i_disp_z),
        .i_end_of_mesh (i_end_of_mesh),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_face_index  (o_face_index),
        .o_a_x         (o_a_x),
        .o_a_y         (o_a_y),
        .o_a_z         (o_a_z),
        .o_b_x         (o_b_x),
        .o_b_y         (o_b_y),
        .o_b_z         (o_b_z),
        .o_last_of_run (o_last_of_run)
    );

endmodule
